// ===== hw/rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, command and status codes, and item types.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_TOTAL_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned COUNT_BITS_DEF = 8;
  localparam int unsigned TAG_BITS       = 4;

  typedef enum logic [2:0] {
    CMD_ALLOC_FIRST = 3'd0,
    CMD_ALLOC_AT    = 3'd1,
    CMD_FREE        = 3'd2,
    CMD_RANGE_ALLOC = 3'd3,
    CMD_RANGE_FREE  = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_USED      = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_RANGE     = 3'd4
  } status_code_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] page_index;
    logic [12:0] page_count;
    logic [3:0]  usage_tag;
  } cmd_item_t;

  typedef struct packed {
    logic [11:0] result_page;
    logic [2:0]  status;
  } result_item_t;

endpackage

// ===== hw/rtl/bpa_map_mem.sv =====
// ----------------------------------------------------------------------------
// Used-bitmap memory
// One word per group of pages, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module bpa_map_mem #(
  parameter int unsigned WORDS = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bpa_rec_mem.sv =====
// ----------------------------------------------------------------------------
// Page record memory
// One record per page, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module bpa_rec_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit physical page allocator over a used-bitmap and page records.
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low; busy then stays
// high until the single result item has been shown on result with done high
// for one cycle. The receiver cannot stall, so each result is taken at once.
// After reset the block runs a clearing pass of one record a cycle, and one
// bitmap word a cycle until the bitmap is clear, with busy high throughout.
// Single-page commands step through the record and bitmap reads, the hold
// of the record and the write-back, then present the result. Allocate first
// free reads one bitmap word a cycle from the bottom, then runs the same
// steps on the lowest free page, or reports no free page when the store is
// full. Range commands visit one page at a time (record read, bitmap read,
// write-back), then present the result. Both memories have a single read
// port, and the read-modify-write of each page is completed before the next
// page is read, so no forwarding is needed.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int unsigned PAGE_TOTAL = bpa_pkg::PAGE_TOTAL_DEF,
  parameter int unsigned WORD_BITS  = bpa_pkg::WORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = bpa_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bpa_pkg::cmd_item_t   cmd,
  output logic                 busy,
  output logic                 done,
  output bpa_pkg::result_item_t result
);

  localparam int unsigned MAP_WORDS = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PW = $clog2(PAGE_TOTAL);
  localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned REC_W = COUNT_BITS + 1 + bpa_pkg::TAG_BITS;
  localparam int unsigned XW = PW + 2;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_RREC  = 8'b0000_1000,
    S_RMAP  = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t state;
  bpa_pkg::cmd_item_t  item;
  logic [XW-1:0]       page;
  logic [XW-1:0]       last;
  logic [WW:0]         scan_addr;
  logic                scan_rd;
  logic [2:0]          status;
  logic [11:0]         rpage;

  logic                 map_we;
  logic [WW-1:0]        map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WW-1:0]        map_raddr;
  logic [WORD_BITS-1:0] map_rdata;
  logic                 rec_we;
  logic [PW-1:0]        rec_waddr;
  logic [REC_W-1:0]     rec_wdata;
  logic [PW-1:0]        rec_raddr;
  logic [REC_W-1:0]     rec_rdata;

  logic [REC_W-1:0]     rec_hold;
  logic [BW-1:0]        low_bit;
  logic                 low_found;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic                 is_alloc;
  logic                 is_huge;
  logic                 bit_cur;

  bpa_map_mem #(.WORDS(MAP_WORDS), .WIDTH(WORD_BITS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  bpa_rec_mem #(.DEPTH(PAGE_TOTAL), .WIDTH(REC_W)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  always_comb begin
    low_bit   = '0;
    low_found = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!map_rdata[i]) begin
        low_bit   = BW'(i);
        low_found = 1'b1;
      end
    end
  end

  assign cnt_cur  = rec_hold[COUNT_BITS-1:0];
  assign is_alloc = (item.cmd == bpa_pkg::CMD_ALLOC_FIRST) ||
                    (item.cmd == bpa_pkg::CMD_ALLOC_AT) ||
                    (item.cmd == bpa_pkg::CMD_RANGE_ALLOC);
  assign is_huge  = (item.cmd == bpa_pkg::CMD_RANGE_ALLOC);
  assign bit_cur  = map_rdata[page[BW-1:0]];

  always_comb begin
    map_raddr = page[PW-1:BW];
    rec_raddr = page[PW-1:0];
    if (state == S_SCAN || state == S_IDLE) begin
      map_raddr = scan_addr[WW-1:0];
    end
    map_we    = 1'b0;
    map_waddr = page[PW-1:BW];
    map_wdata = map_rdata;
    rec_we    = 1'b0;
    rec_waddr = page[PW-1:0];
    rec_wdata = rec_hold;
    unique case (state)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_wdata = '0;
        map_we    = (page[PW-1:0] < PW'(MAP_WORDS));
        map_waddr = page[WW-1:0];
        map_wdata = '0;
      end
      S_WB: begin
        if (is_alloc) begin
          if (is_huge || !bit_cur) begin
            rec_we = 1'b1;
            rec_wdata = {item.usage_tag, is_huge,
                         (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1};
            map_we = 1'b1;
            map_wdata[page[BW-1:0]] = 1'b1;
          end
        end else if (cnt_cur != '0) begin
          rec_we = 1'b1;
          rec_wdata = {rec_hold[REC_W-1:COUNT_BITS], cnt_cur - 1'b1};
          map_we = 1'b1;
          map_wdata[page[BW-1:0]] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      page      <= '0;
      done      <= 1'b0;
      scan_addr <= '0;
      scan_rd   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (page == XW'(PAGE_TOTAL - 1)) begin
            state <= S_IDLE;
          end
          page <= page + 1'b1;
        end
        S_IDLE: begin
          scan_addr <= '0;
          scan_rd   <= 1'b0;
          if (start) begin
            item   <= cmd;
            page   <= XW'(cmd.page_index);
            rpage  <= cmd.page_index;
            status <= bpa_pkg::ST_OK;
            last   <= XW'(cmd.page_index) + XW'(cmd.page_count);
            unique case (cmd.cmd)
              bpa_pkg::CMD_ALLOC_FIRST: begin
                state <= S_SCAN;
              end
              bpa_pkg::CMD_ALLOC_AT, bpa_pkg::CMD_FREE: begin
                if (XW'(cmd.page_index) >= XW'(PAGE_TOTAL)) begin
                  status <= bpa_pkg::ST_RANGE;
                  state  <= S_DONE;
                end else begin
                  last  <= XW'(cmd.page_index) + 1'b1;
                  state <= S_RREC;
                end
              end
              bpa_pkg::CMD_RANGE_ALLOC, bpa_pkg::CMD_RANGE_FREE: begin
                if (XW'(cmd.page_index) + XW'(cmd.page_count) > XW'(PAGE_TOTAL)) begin
                  status <= bpa_pkg::ST_RANGE;
                  state  <= S_DONE;
                end else if (cmd.page_count == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_RREC;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_rd && low_found &&
              ((XW'(scan_addr - 1'b1) << BW) + XW'(low_bit)) < XW'(PAGE_TOTAL) &&
              ((XW'(scan_addr - 1'b1) << BW) < XW'(PAGE_TOTAL))) begin
            page  <= (XW'(scan_addr - 1'b1) << BW) | XW'(low_bit);
            rpage <= 12'((XW'(scan_addr - 1'b1) << BW) | XW'(low_bit));
            last  <= ((XW'(scan_addr - 1'b1) << BW) | XW'(low_bit)) + 1'b1;
            state <= S_RREC;
          end else if (scan_addr == (WW+1)'(MAP_WORDS)) begin
            rpage  <= '0;
            status <= bpa_pkg::ST_NO_FREE;
            state  <= S_DONE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
            scan_rd   <= 1'b1;
          end
        end
        S_RREC: begin
          state <= S_RMAP;
        end
        S_RMAP: begin
          rec_hold <= rec_rdata;
          state    <= S_WB;
        end
        S_WB: begin
          if (item.cmd == bpa_pkg::CMD_ALLOC_AT && bit_cur) begin
            status <= bpa_pkg::ST_USED;
          end
          if (item.cmd == bpa_pkg::CMD_FREE && cnt_cur == '0) begin
            status <= bpa_pkg::ST_NOT_ALLOC;
          end
          if (page + 1'b1 == last) begin
            state <= S_DONE;
          end else begin
            state <= S_RREC;
          end
          page <= page + 1'b1;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign result.result_page = rpage;
  assign result.status      = status;

endmodule

// ===== test/bitmap_page_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives command items with random gaps, save for one stretch without gaps,
// and checks every result item against a cycle-free model of the used bitmap and page records.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;

  localparam int PAGES = 4096;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    bpa_pkg::cmd_item_t    item;
    logic                  known;
    bpa_pkg::result_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  bpa_pkg::cmd_item_t cmd = '0;
  logic busy, done;
  bpa_pkg::result_item_t result;

  logic         page_used [PAGES];
  logic [7:0]   page_refs [PAGES];
  logic         page_huge [PAGES];
  logic [3:0]   page_tag  [PAGES];
  bpa_pkg::result_item_t pending_results [$];
  row_t         rows [$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int ranges_sent = 0;
  bit quiet = 1'b0;

  bitmap_page_allocator dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic void claim(input int pg, input logic huge, input logic [3:0] tag);
    if (page_refs[pg] != 8'hff) page_refs[pg]++;
    page_huge[pg] = huge;
    page_tag[pg] = tag;
    page_used[pg] = 1'b1;
  endfunction

  function automatic logic release_page(input int pg);
    if (page_refs[pg] == 0) return 1'b0;
    page_refs[pg]--;
    page_used[pg] = 1'b0;
    return 1'b1;
  endfunction

  function automatic bpa_pkg::result_item_t allocate_outcome(input bpa_pkg::cmd_item_t c);
    bpa_pkg::result_item_t r;
    int k;
    r.result_page = c.page_index;
    r.status = bpa_pkg::ST_OK;
    case (c.cmd)
      bpa_pkg::CMD_ALLOC_FIRST: begin
        r.result_page = '0;
        r.status = bpa_pkg::ST_NO_FREE;
        for (k = 0; k < PAGES; k++) begin
          if (!page_used[k]) begin
            claim(k, 1'b0, c.usage_tag);
            r.result_page = k[11:0];
            r.status = bpa_pkg::ST_OK;
            break;
          end
        end
      end
      bpa_pkg::CMD_ALLOC_AT: begin
        if (page_used[c.page_index]) r.status = bpa_pkg::ST_USED;
        else claim(c.page_index, 1'b0, c.usage_tag);
      end
      bpa_pkg::CMD_FREE: begin
        if (!release_page(c.page_index)) r.status = bpa_pkg::ST_NOT_ALLOC;
      end
      bpa_pkg::CMD_RANGE_ALLOC, bpa_pkg::CMD_RANGE_FREE: begin
        if (int'(c.page_index) + int'(c.page_count) > PAGES) begin
          r.status = bpa_pkg::ST_RANGE;
        end else begin
          for (k = 0; k < c.page_count; k++) begin
            if (c.cmd == bpa_pkg::CMD_RANGE_ALLOC) claim(c.page_index + k, 1'b1, c.usage_tag);
            else void'(release_page(c.page_index + k));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    bpa_pkg::result_item_t w;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        w = pending_results.pop_front();
        if (result.result_page !== w.result_page)
          report($sformatf("page %0d, wanted %0d", result.result_page, w.result_page));
        if (result.status !== w.status)
          report($sformatf("status %0d, wanted %0d", result.status, w.status));
      end
    end
  end

  function automatic bpa_pkg::cmd_item_t make_item(input logic [2:0] c, input int idx,
                                                   input int cnt, input int tag);
    bpa_pkg::cmd_item_t it;
    it.cmd = c;
    it.page_index = idx[11:0];
    it.page_count = cnt[12:0];
    it.usage_tag = tag[3:0];
    return it;
  endfunction

  function automatic void add_row(input bpa_pkg::cmd_item_t it, input logic known,
                                  input logic [11:0] pg, input bpa_pkg::status_code_t st);
    row_t r;
    r.item = it;
    r.known = known;
    r.want.result_page = pg;
    r.want.status = st;
    rows.push_back(r);
  endfunction

  task automatic send(input bpa_pkg::cmd_item_t it, input logic known,
                      input bpa_pkg::result_item_t want);
    bpa_pkg::result_item_t w;
    while (!quiet && $urandom_range(99) < 29) @(posedge clk);
    start <= 1'b1;
    cmd <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = allocate_outcome(it);
    if (known && w !== want) report("directed row disagrees with the model");
    pending_results.push_back(known ? want : w);
    if (it.cmd == bpa_pkg::CMD_RANGE_ALLOC || it.cmd == bpa_pkg::CMD_RANGE_FREE) ranges_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bpa_pkg::cmd_item_t random_item();
    int c, idx, cnt, sel;
    sel = $urandom_range(99);
    idx = (sel < 50) ? $urandom_range(255) : $urandom_range(4095);
    cnt = $urandom_range(9);
    if (sel < 30) c = bpa_pkg::CMD_ALLOC_FIRST;
    else if (sel < 50) c = bpa_pkg::CMD_ALLOC_AT;
    else if (sel < 72) c = bpa_pkg::CMD_FREE;
    else if (sel < 84) c = bpa_pkg::CMD_RANGE_ALLOC;
    else if (sel < 95) c = bpa_pkg::CMD_RANGE_FREE;
    else c = $urandom_range(7);
    if (sel == 83 || sel == 94) cnt = $urandom_range(4096);
    if (sel == 82) idx = 4096 - cnt + $urandom_range(1);
    return make_item(c[2:0], idx, cnt, $urandom_range(15));
  endfunction

  initial begin
    int i;
    int gap;
    bpa_pkg::result_item_t none;
    none = '0;
    for (i = 0; i < PAGES; i++) begin
      page_used[i] = 1'b0;
      page_refs[i] = '0;
      page_huge[i] = 1'b0;
      page_tag[i] = '0;
    end

    add_row(make_item(bpa_pkg::CMD_FREE, 0, 0, 0), 1'b1, 12'd0, bpa_pkg::ST_NOT_ALLOC);
    add_row(make_item(bpa_pkg::CMD_ALLOC_FIRST, 4095, 0, 15), 1'b1, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_FIRST, 0, 0, 0), 1'b1, 12'd1, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_AT, 0, 0, 3), 1'b1, 12'd0, bpa_pkg::ST_USED);
    add_row(make_item(bpa_pkg::CMD_ALLOC_AT, 4095, 8191, 15), 1'b1, 12'd4095, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_FREE, 4095, 0, 0), 1'b1, 12'd4095, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_FREE, 4095, 0, 0), 1'b1, 12'd4095, bpa_pkg::ST_NOT_ALLOC);
    add_row(make_item(bpa_pkg::CMD_RANGE_ALLOC, 4095, 2, 5), 1'b1, 12'd4095, bpa_pkg::ST_RANGE);
    add_row(make_item(bpa_pkg::CMD_RANGE_FREE, 1, 4096, 0), 1'b1, 12'd1, bpa_pkg::ST_RANGE);
    add_row(make_item(bpa_pkg::CMD_RANGE_ALLOC, 100, 0, 9), 1'b1, 12'd100, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_RANGE_ALLOC, 0, 40, 10), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_FIRST, 0, 0, 1), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_RANGE_FREE, 30, 20, 0), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_FIRST, 0, 0, 2), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(3'd5, 1234, 77, 6), 1'b1, 12'd1234, bpa_pkg::ST_OK);
    add_row(make_item(3'd7, 4095, 8191, 15), 1'b1, 12'd4095, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_RANGE_ALLOC, 0, 4096, 15), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_FIRST, 0, 0, 0), 1'b1, 12'd0, bpa_pkg::ST_NO_FREE);
    add_row(make_item(bpa_pkg::CMD_RANGE_FREE, 0, 4096, 0), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_RANGE_FREE, 0, 4096, 0), 1'b0, 12'd0, bpa_pkg::ST_OK);
    add_row(make_item(bpa_pkg::CMD_ALLOC_AT, 2730, 0, 10), 1'b0, 12'd0, bpa_pkg::ST_OK);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].item, rows[i].known, rows[i].want);

    for (i = 0; i < 1300; i++) begin
      quiet = (i >= 400 && i < 600);
      if (i == 700) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
      send(random_item(), 1'b0, none);
    end

    gap = 0;
    while (pending_results.size() != 0 && gap < 20000) begin
      @(posedge clk);
      gap++;
    end
    repeat (50) @(posedge clk);

    $display("Covered %0d result items, %0d of them from range commands,",
             results_seen, ranges_sent);
    $display("including a full store, first-fit scans and out-of-range ranges.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_map_mem.sv
hw/rtl/bpa_rec_mem.sv
hw/rtl/bitmap_page_allocator.sv
test/bitmap_page_allocator_test.sv
